// ===== rtl/core/dvbclut_pkg.sv =====
// dvbclut_pkg: types, constants and the per-byte parse function of the
// dvb subtitle clut segment parser; no dependencies
package dvbclut_pkg;

	localparam logic [7:0]  SYNC_BYTE      = 8'h0F;
	localparam logic [7:0]  CLUT_SEGMENT   = 8'h12;
	localparam logic [31:0] LEAD_SIGNATURE = 32'h000f0020;
	localparam logic [7:0]  LEAD_BYTE0     = LEAD_SIGNATURE[7:0];
	localparam logic [7:0]  LEAD_BYTE1     = LEAD_SIGNATURE[15:8];
	localparam logic [7:0]  LEAD_BYTE2     = LEAD_SIGNATURE[23:16];
	localparam logic [7:0]  FULL_SCALE     = 8'd255;

	typedef enum logic [3:0] {
		PH_HUNT        = 4'd0,
		PH_TYPE        = 4'd1,
		PH_PAGE_HI     = 4'd2,
		PH_PAGE_LO     = 4'd3,
		PH_LEN_HI      = 4'd4,
		PH_LEN_LO      = 4'd5,
		PH_SKIP        = 4'd6,
		PH_CLUT_ID     = 4'd7,
		PH_VERSION     = 4'd8,
		PH_ENTRY_ID    = 4'd9,
		PH_ENTRY_FLAGS = 4'd10,
		PH_COMPONENTS  = 4'd11
	} phase_t;

	// segment parser state
	typedef struct packed {
		phase_t      phase;
		logic [7:0]  kind;
		logic [15:0] page;
		logic [15:0] remaining;
		logic [7:0]  table_id;
		logic [3:0]  table_version;
		logic [7:0]  entry_index;
		logic [3:0]  entry_flags;
		logic [23:0] comp_buf;
		logic [2:0]  comp_count;
	} pst_t;

	// chunk lead detector state
	typedef struct packed {
		logic       locked;
		logic [1:0] lead_match;
	} lead_t;

	// one palette write
	typedef struct packed {
		logic [15:0] page_id;
		logic [7:0]  clut_id;
		logic [3:0]  clut_version;
		logic [7:0]  palette_index;
		logic [7:0]  luma;
		logic [7:0]  chroma_red;
		logic [7:0]  chroma_blue;
		logic [7:0]  opacity;
		logic [2:0]  depth_flags;
		logic        full_range;
	} res_t;

	typedef struct packed {
		pst_t st;
		logic emit;
		res_t res;
	} feed_t;

	// advance the parser by one byte
	function automatic feed_t feed(logic locked, pst_t st, logic [7:0] b);
		feed_t       f;
		logic [15:0] rem_n;
		logic        body;
		logic        last;
		f      = '0;
		f.st   = st;
		body   = 1'b0;
		last   = st.entry_flags[0] ? (st.comp_count >= 3'd3) : (st.comp_count >= 3'd1);
		rem_n  = (st.remaining != 16'd0) ? st.remaining - 16'd1 : st.remaining;
		if (locked) begin
			unique case (st.phase)
				PH_TYPE: begin
					f.st.kind  = b;
					f.st.phase = PH_PAGE_HI;
				end
				PH_PAGE_HI: begin
					f.st.page  = {b, 8'h00};
					f.st.phase = PH_PAGE_LO;
				end
				PH_PAGE_LO: begin
					f.st.page  = {st.page[15:8], b};
					f.st.phase = PH_LEN_HI;
				end
				PH_LEN_HI: begin
					f.st.remaining = {b, 8'h00};
					f.st.phase     = PH_LEN_LO;
				end
				PH_LEN_LO: begin
					f.st.remaining = {st.remaining[15:8], b};
					if ({st.remaining[15:8], b} == 16'd0) begin
						f.st.phase = PH_HUNT;
					end else if (st.kind == CLUT_SEGMENT) begin
						f.st.phase = PH_CLUT_ID;
					end else begin
						f.st.phase = PH_SKIP;
					end
				end
				PH_SKIP: begin
					body = 1'b1;
				end
				PH_CLUT_ID: begin
					f.st.table_id = b;
					f.st.phase    = PH_VERSION;
					body          = 1'b1;
				end
				PH_VERSION: begin
					f.st.table_version = b[7:4];
					f.st.phase         = PH_ENTRY_ID;
					body               = 1'b1;
				end
				PH_ENTRY_ID: begin
					f.st.entry_index = b;
					f.st.phase       = PH_ENTRY_FLAGS;
					body             = 1'b1;
				end
				PH_ENTRY_FLAGS: begin
					f.st.entry_flags = {b[7:5], b[0]};
					f.st.comp_count  = 3'd0;
					f.st.comp_buf    = 24'd0;
					f.st.phase       = PH_COMPONENTS;
					body             = 1'b1;
				end
				PH_COMPONENTS: begin
					body = 1'b1;
					if (last) begin
						f.emit              = 1'b1;
						f.res.page_id       = st.page;
						f.res.clut_id       = st.table_id;
						f.res.clut_version  = st.table_version;
						f.res.palette_index = st.entry_index + 8'd1;
						f.res.depth_flags   = st.entry_flags[3:1];
						f.res.full_range    = st.entry_flags[0];
						if (st.entry_flags[0]) begin
							f.res.luma        = st.comp_buf[23:16];
							f.res.chroma_red  = st.comp_buf[15:8];
							f.res.chroma_blue = st.comp_buf[7:0];
							f.res.opacity     = FULL_SCALE - b;
						end else begin
							f.res.luma        = {st.comp_buf[7:2], 2'b00};
							f.res.chroma_red  = {st.comp_buf[1:0], b[7:6], 4'h0};
							f.res.chroma_blue = {b[5:2], 4'h0};
							f.res.opacity     = FULL_SCALE - {b[1:0], 6'h00};
						end
						f.st.comp_count = 3'd0;
						f.st.comp_buf   = 24'd0;
						f.st.phase      = PH_ENTRY_ID;
					end else begin
						f.st.comp_buf   = {st.comp_buf[15:0], b};
						f.st.comp_count = st.comp_count + 3'd1;
					end
				end
				default: begin
					f.st.phase = (b == SYNC_BYTE) ? PH_TYPE : PH_HUNT;
				end
			endcase
			if (body) begin
				f.st.remaining = rem_n;
				if (rem_n == 16'd0) begin
					f.st.phase = PH_HUNT;
				end
			end
		end
		return f;
	endfunction

endpackage

// ===== rtl/core/dvb_subtitle_clut_segment_parser.sv =====
// dvb_subtitle_clut_segment_parser: top level of the dvb subtitle clut
// segment parser; depends on dvbclut_pkg and dvbclut_step
//
// input channel: one payload byte per beat on data_byte, chunk_start high
//   on the first byte of a sample chunk, handshake in_valid / in_stall
// output channel: one palette write per beat (page, clut id and version,
//   index, y / cr / cb / opacity, depth flags, full range), handshake
//   out_valid / out_stall
// the parser stays silent until a chunk opens with 0x20 0x00 0x0f, then
//   hunts sync bytes, reads segment headers, decodes clut entries and
//   skips every other segment by its length
// path: an accepted byte waits in the input register and is parsed from
//   there; its palette write, if any, is loaded into the result register
//   and shows on out_valid from that register
// throughput: one byte per cycle unless stalled; lead check plus up to
//   three parser byte steps sit between the input and result registers
// stall: the result register holds while out_stall is high; bytes that
//   yield no palette write keep flowing, a byte that yields one waits in
//   the input register while the result register is full and stalled
// reset: arst_n low clears lock, lead and parser state and empties both stages
module dvb_subtitle_clut_segment_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        chunk_start,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] page_id,
	output logic [7:0]  clut_id,
	output logic [3:0]  clut_version,
	output logic [7:0]  palette_index,
	output logic [7:0]  luma,
	output logic [7:0]  chroma_red,
	output logic [7:0]  chroma_blue,
	output logic [7:0]  opacity,
	output logic [2:0]  depth_flags,
	output logic        full_range
);

	// input stage
	logic               valid_s1;
	logic [7:0]         byte_s1;
	logic               start_s1;

	// parser state
	dvbclut_pkg::lead_t lead_q;
	dvbclut_pkg::pst_t  st_q;

	// step outputs
	dvbclut_pkg::lead_t lead_next;
	dvbclut_pkg::pst_t  st_next;
	logic               emit;
	dvbclut_pkg::res_t  res;

	// result register
	logic               out_valid_q;
	dvbclut_pkg::res_t  res_q;

	logic               out_free;
	logic               advance;
	logic               in_take;

	dvbclut_step u_step (
		.lead        (lead_q),
		.st          (st_q),
		.data_byte   (byte_s1),
		.chunk_start (start_s1),
		.lead_next   (lead_next),
		.st_next     (st_next),
		.emit        (emit),
		.res         (res)
	);

	// result register is free when empty or being taken this edge
	assign out_free = !out_valid_q || !out_stall;
	// the staged byte moves on unless its palette write has nowhere to go
	assign advance  = valid_s1 && (!emit || out_free);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// staged payload, no reset
	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1  <= data_byte;
			start_s1 <= chunk_start;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_q <= '0;
			st_q   <= '0;
		end else if (advance) begin
			lead_q <= lead_next;
			st_q   <= st_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// palette write payload, loaded only when the register is free
	always_ff @(posedge clk) begin
		if (advance && emit) begin
			res_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign page_id       = res_q.page_id;
	assign clut_id       = res_q.clut_id;
	assign clut_version  = res_q.clut_version;
	assign palette_index = res_q.palette_index;
	assign luma          = res_q.luma;
	assign chroma_red    = res_q.chroma_red;
	assign chroma_blue   = res_q.chroma_blue;
	assign opacity       = res_q.opacity;
	assign depth_flags   = res_q.depth_flags;
	assign full_range    = res_q.full_range;

endmodule

// ===== rtl/core/dvbclut_step.sv =====
// dvbclut_step: chunk lead detection plus up to three parser byte steps
// for one input beat; depends on dvbclut_pkg
module dvbclut_step (
	input  dvbclut_pkg::lead_t lead,
	input  dvbclut_pkg::pst_t  st,
	input  logic [7:0]         data_byte,
	input  logic               chunk_start,
	output dvbclut_pkg::lead_t lead_next,
	output dvbclut_pkg::pst_t  st_next,
	output logic               emit,
	output dvbclut_pkg::res_t  res
);

	always_comb begin
		dvbclut_pkg::feed_t f1;
		dvbclut_pkg::feed_t f2;
		dvbclut_pkg::feed_t f3;
		dvbclut_pkg::pst_t  st0;
		logic               replay;
		logic               feed_cur;
		logic               relock;
		logic               lk;
		replay    = 1'b0;
		feed_cur  = 1'b1;
		relock    = 1'b0;
		lead_next = lead;
		if (chunk_start) begin
			replay = 1'b1;
			if (data_byte == dvbclut_pkg::LEAD_BYTE0) begin
				feed_cur             = 1'b0;
				lead_next.lead_match = 2'd1;
			end else begin
				lead_next.lead_match = 2'd0;
			end
		end else if (lead.lead_match == 2'd1) begin
			if (data_byte == dvbclut_pkg::LEAD_BYTE1) begin
				feed_cur             = 1'b0;
				lead_next.lead_match = 2'd2;
			end else begin
				replay               = 1'b1;
				lead_next.lead_match = 2'd0;
			end
		end else if (lead.lead_match == 2'd2) begin
			lead_next.lead_match = 2'd0;
			if (data_byte == dvbclut_pkg::LEAD_BYTE2) begin
				relock           = 1'b1;
				lead_next.locked = 1'b1;
			end else begin
				replay = 1'b1;
			end
		end else begin
			lead_next.lead_match = 2'd0;
		end

		// held lead bytes go through the parser first, in order
		lk = lead.locked;
		if (replay && lead.lead_match >= 2'd1) begin
			f1 = dvbclut_pkg::feed(lk, st, dvbclut_pkg::LEAD_BYTE0);
		end else begin
			f1      = '0;
			f1.st   = st;
		end
		if (replay && lead.lead_match >= 2'd2) begin
			f2 = dvbclut_pkg::feed(lk, f1.st, dvbclut_pkg::LEAD_BYTE1);
		end else begin
			f2    = '0;
			f2.st = f1.st;
		end
		st0 = f2.st;
		if (relock) begin
			st0.phase = dvbclut_pkg::PH_HUNT;
		end
		if (feed_cur) begin
			f3 = dvbclut_pkg::feed(lead_next.locked, st0, data_byte);
		end else begin
			f3    = '0;
			f3.st = st0;
		end

		st_next = f3.st;
		emit    = f1.emit | f2.emit | f3.emit;
		// only the first palette write of a beat is kept
		if (f1.emit) begin
			res = f1.res;
		end else if (f2.emit) begin
			res = f2.res;
		end else begin
			res = f3.res;
		end
	end

endmodule

// ===== rtl/core/dvbclut_checker.sv =====
// dvbclut_checker: port-level assertions for the dvb subtitle clut segment
// parser, bound to the top level; no package dependency
module dvbclut_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [15:0] page_id,
	input logic [7:0]  clut_id,
	input logic [3:0]  clut_version,
	input logic [7:0]  palette_index,
	input logic [7:0]  luma,
	input logic [7:0]  chroma_red,
	input logic [7:0]  chroma_blue,
	input logic [7:0]  opacity,
	input logic [2:0]  depth_flags,
	input logic        full_range
);

	// a stalled palette write stays
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("out_valid dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(page_id) && $stable(clut_id)
			&& $stable(clut_version) && $stable(palette_index) && $stable(luma)
			&& $stable(chroma_red) && $stable(chroma_blue) && $stable(opacity)
			&& $stable(depth_flags) && $stable(full_range))
		else $error("stalled palette write changed");

	// input side only backs up behind a stalled output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output backpressure");

	// a fresh palette write traces back to a byte taken through the input register
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 2))
		else $error("palette write without a byte two edges earlier");

	// partial range entries have fixed low bits
	a_partial: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !full_range |-> luma[1:0] == 2'b00 && chroma_red[3:0] == 4'h0
			&& chroma_blue[3:0] == 4'h0 && opacity[5:0] == 6'h3F)
		else $error("partial range entry with bad low bits");

endmodule

bind dvb_subtitle_clut_segment_parser dvbclut_checker u_dvbclut_checker (.*);

// ===== test/testbench.sv =====
// testbench for dvb_subtitle_clut_segment_parser: drives payload beats, predicts
// every palette write in its own parser model and compares each result beat
// depends on dvbclut_pkg and the parser rtl only
`timescale 1ns / 100ps

module testbench;

	localparam int         CYCLE_LIMIT  = 200000;
	localparam int         HOLD_CYCLES  = 200;
	localparam int         IDLE_PERCENT = 13;
	localparam int         REPORT_LIMIT = 10;
	localparam int         TAIL_CYCLES  = 8;
	localparam logic [7:0] PAGE_SEGMENT = 8'h10;

	// entry component mode chosen when building a clut body
	typedef enum int {PARTIAL_ONLY, FULL_ONLY, MIXED} entry_mix_t;

	// one payload beat waiting to be sent
	typedef struct packed {
		logic [7:0] data;
		logic       start;
	} beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte = 8'h00;
	logic        chunk_start = 1'b0;
	logic        out_valid;
	logic        out_stall;
	logic [15:0] page_id;
	logic [7:0]  clut_id;
	logic [3:0]  clut_version;
	logic [7:0]  palette_index;
	logic [7:0]  luma;
	logic [7:0]  chroma_red;
	logic [7:0]  chroma_blue;
	logic [7:0]  opacity;
	logic [2:0]  depth_flags;
	logic        full_range;

	dvb_subtitle_clut_segment_parser dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.data_byte     (data_byte),
		.chunk_start   (chunk_start),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.page_id       (page_id),
		.clut_id       (clut_id),
		.clut_version  (clut_version),
		.palette_index (palette_index),
		.luma          (luma),
		.chroma_red    (chroma_red),
		.chroma_blue   (chroma_blue),
		.opacity       (opacity),
		.depth_flags   (depth_flags),
		.full_range    (full_range)
	);

	always #5 clk = ~clk;

	// ---------------------------------------------------------------
	// parser model state, updated once per accepted input beat
	// ---------------------------------------------------------------
	logic                lock_seen = 1'b0;   // a chunk has opened with the lead pattern
	logic [1:0]          lead_held = 2'd0;   // how many lead bytes are held back
	dvbclut_pkg::phase_t seg_phase = dvbclut_pkg::PH_HUNT;
	logic [7:0]          seg_kind = 8'h00;
	logic [15:0]         seg_page = 16'h0000;
	logic [15:0]         seg_left = 16'h0000; // body bytes still to come
	logic [7:0]          clut_tab = 8'h00;
	logic [3:0]          clut_ver = 4'h0;
	logic [7:0]          entry_num = 8'h00;
	logic [3:0]          entry_mode = 4'h0;  // depth flags over the full range flag
	logic [23:0]         comp_bytes = 24'h0;
	logic [2:0]          comp_seen = 3'd0;

	// at most one palette write per input beat
	logic                write_ready;
	dvbclut_pkg::res_t   write_next;
	dvbclut_pkg::res_t   palette_writes_due[$];

	// stimulus and run bookkeeping
	beat_t       pending[$];
	logic [7:0]  body_bytes[$];
	bit          gaps_on = 1'b1;
	bit          stall_on = 1'b1;
	int          hold_armed = 0;     // bumped by a test to ask for a long hold-off
	int          hold_seen = 0;
	int          hold_left = 0;
	int          beats_sent = 0;
	int          writes_checked = 0;
	int          mismatches = 0;
	int          cycles = 0;
	dvbclut_pkg::res_t due_w;

	// every body byte of a segment counts down its length
	function automatic void count_segment_byte();
		if (seg_left != 16'd0)
			seg_left = seg_left - 16'd1;
		if (seg_left == 16'd0)
			seg_phase = dvbclut_pkg::PH_HUNT;
	endfunction

	// one byte into the segment parser; only the first write of a beat is kept
	function automatic void parse_payload_byte(input logic [7:0] b);
		dvbclut_pkg::res_t w;
		logic [7:0]        b0;
		if (!lock_seen)
			return;
		case (seg_phase)
			dvbclut_pkg::PH_TYPE: begin
				seg_kind = b;
				seg_phase = dvbclut_pkg::PH_PAGE_HI;
			end
			dvbclut_pkg::PH_PAGE_HI: begin
				seg_page = {b, 8'h00};
				seg_phase = dvbclut_pkg::PH_PAGE_LO;
			end
			dvbclut_pkg::PH_PAGE_LO: begin
				seg_page[7:0] = b;
				seg_phase = dvbclut_pkg::PH_LEN_HI;
			end
			dvbclut_pkg::PH_LEN_HI: begin
				seg_left = {b, 8'h00};
				seg_phase = dvbclut_pkg::PH_LEN_LO;
			end
			dvbclut_pkg::PH_LEN_LO: begin
				seg_left[7:0] = b;
				// an empty segment has no body at all
				if (seg_left == 16'd0)
					seg_phase = dvbclut_pkg::PH_HUNT;
				else if (seg_kind == dvbclut_pkg::CLUT_SEGMENT)
					seg_phase = dvbclut_pkg::PH_CLUT_ID;
				else
					seg_phase = dvbclut_pkg::PH_SKIP;
			end
			dvbclut_pkg::PH_SKIP: begin
				count_segment_byte();
			end
			dvbclut_pkg::PH_CLUT_ID: begin
				clut_tab = b;
				seg_phase = dvbclut_pkg::PH_VERSION;
				count_segment_byte();
			end
			dvbclut_pkg::PH_VERSION: begin
				clut_ver = b[7:4];
				seg_phase = dvbclut_pkg::PH_ENTRY_ID;
				count_segment_byte();
			end
			dvbclut_pkg::PH_ENTRY_ID: begin
				entry_num = b;
				seg_phase = dvbclut_pkg::PH_ENTRY_FLAGS;
				count_segment_byte();
			end
			dvbclut_pkg::PH_ENTRY_FLAGS: begin
				entry_mode = {b[7:5], b[0]};
				comp_seen = 3'd0;
				comp_bytes = 24'h0;
				seg_phase = dvbclut_pkg::PH_COMPONENTS;
				count_segment_byte();
			end
			dvbclut_pkg::PH_COMPONENTS: begin
				// full range entries carry y cr cb t, partial ones pack them in two bytes
				if (int'(comp_seen) + 1 >= (entry_mode[0] ? 4 : 2)) begin
					w.page_id = seg_page;
					w.clut_id = clut_tab;
					w.clut_version = clut_ver;
					w.palette_index = entry_num + 8'd1;
					w.depth_flags = entry_mode[3:1];
					w.full_range = entry_mode[0];
					if (entry_mode[0]) begin
						w.luma = comp_bytes[23:16];
						w.chroma_red = comp_bytes[15:8];
						w.chroma_blue = comp_bytes[7:0];
						w.opacity = dvbclut_pkg::FULL_SCALE - b;
					end else begin
						b0 = comp_bytes[7:0];
						w.luma = {b0[7:2], 2'b00};
						w.chroma_red = {b0[1:0], b[7:6], 4'h0};
						w.chroma_blue = {b[5:2], 4'h0};
						w.opacity = dvbclut_pkg::FULL_SCALE - {b[1:0], 6'h00};
					end
					if (!write_ready) begin
						write_ready = 1'b1;
						write_next = w;
					end
					comp_seen = 3'd0;
					comp_bytes = 24'h0;
					seg_phase = dvbclut_pkg::PH_ENTRY_ID;
				end else begin
					comp_bytes = {comp_bytes[15:0], b};
					comp_seen = comp_seen + 3'd1;
				end
				count_segment_byte();
			end
			default: begin
				seg_phase = (b == dvbclut_pkg::SYNC_BYTE) ? dvbclut_pkg::PH_TYPE
					: dvbclut_pkg::PH_HUNT;
			end
		endcase
	endfunction

	// held lead bytes turn out to be plain data
	function automatic void replay_lead_bytes();
		if (lead_held >= 2'd1)
			parse_payload_byte(dvbclut_pkg::LEAD_BYTE0);
		if (lead_held >= 2'd2)
			parse_payload_byte(dvbclut_pkg::LEAD_BYTE1);
		lead_held = 2'd0;
	endfunction

	// one accepted beat: chunk lead detection, then the parser
	function automatic void predict_palette_write(input logic [7:0] b, input logic s);
		write_ready = 1'b0;
		if (s) begin
			replay_lead_bytes();
			if (b == dvbclut_pkg::LEAD_BYTE0)
				lead_held = 2'd1;
			else
				parse_payload_byte(b);
		end else if (lead_held == 2'd1) begin
			if (b == dvbclut_pkg::LEAD_BYTE1) begin
				lead_held = 2'd2;
			end else begin
				replay_lead_bytes();
				parse_payload_byte(b);
			end
		end else if (lead_held == 2'd2) begin
			if (b == dvbclut_pkg::LEAD_BYTE2) begin
				// lock or relock: the open segment is dropped, this byte is the sync
				lead_held = 2'd0;
				lock_seen = 1'b1;
				seg_phase = dvbclut_pkg::PH_HUNT;
				parse_payload_byte(b);
			end else begin
				replay_lead_bytes();
				parse_payload_byte(b);
			end
		end else begin
			parse_payload_byte(b);
		end
		if (write_ready)
			palette_writes_due.insert(palette_writes_due.size(), write_next);
	endfunction

	// ---------------------------------------------------------------
	// stream building
	// ---------------------------------------------------------------
	function automatic void put(input logic [7:0] b, input logic s);
		pending.insert(pending.size(), beat_t'{b, s});
	endfunction

	function automatic void add_body(input logic [7:0] b);
		body_bytes.insert(body_bytes.size(), b);
	endfunction

	// the segment's own sync byte completes the lead pattern
	function automatic void put_lead();
		put(dvbclut_pkg::LEAD_BYTE0, 1'b1);
		put(dvbclut_pkg::LEAD_BYTE1, 1'b0);
	endfunction

	// sync, header with the given length field, then whatever body was built
	function automatic void put_segment(input logic [7:0] kind, input logic [15:0] page,
			input logic [15:0] len);
		put(dvbclut_pkg::SYNC_BYTE, 1'b0);
		put(kind, 1'b0);
		put(page[15:8], 1'b0);
		put(page[7:0], 1'b0);
		put(len[15:8], 1'b0);
		put(len[7:0], 1'b0);
		foreach (body_bytes[i])
			put(body_bytes[i], 1'b0);
		body_bytes.delete();
	endfunction

	function automatic void build_clut_body(input int entries, input entry_mix_t mix);
		logic [7:0] flags;
		body_bytes.delete();
		add_body(8'($urandom));
		add_body(8'($urandom));
		repeat (entries) begin
			flags = 8'($urandom);
			if (mix == PARTIAL_ONLY)
				flags[0] = 1'b0;
			else if (mix == FULL_ONLY)
				flags[0] = 1'b1;
			add_body(8'($urandom));
			add_body(flags);
			repeat (flags[0] ? 4 : 2)
				add_body(8'($urandom));
		end
	endfunction

	// clut, other or empty segment with a matching length field
	function automatic void put_good_segment();
		int         pick;
		logic [7:0] kind;
		pick = $urandom_range(99);
		if (pick < 70) begin
			build_clut_body($urandom_range(1, 5), MIXED);
			put_segment(dvbclut_pkg::CLUT_SEGMENT, 16'($urandom), 16'(body_bytes.size()));
		end else if (pick < 85) begin
			kind = 8'($urandom);
			if (kind == dvbclut_pkg::CLUT_SEGMENT)
				kind = PAGE_SEGMENT;
			body_bytes.delete();
			repeat ($urandom_range(0, 12))
				add_body(8'($urandom));
			put_segment(kind, 16'($urandom), 16'(body_bytes.size()));
		end else begin
			body_bytes.delete();
			put_segment(8'($urandom), 16'($urandom), 16'd0);
		end
	endfunction

	// broken leads, early chunk ends, cut or overlong segments, raw noise
	function automatic void put_broken_framing();
		int         pick;
		logic [7:0] b;
		logic [15:0] len;
		pick = $urandom_range(99);
		if (pick < 17) begin
			// lead stops after its first byte
			put(dvbclut_pkg::LEAD_BYTE0, 1'b1);
			put(8'($urandom_range(1, 255)), 1'b0);
		end else if (pick < 34) begin
			// lead stops after its second byte
			b = 8'($urandom);
			if (b == dvbclut_pkg::LEAD_BYTE2)
				b = b ^ 8'h01;
			put_lead();
			put(b, 1'($urandom));
		end else if (pick < 50) begin
			// chunk ends while lead bytes are held
			put(dvbclut_pkg::LEAD_BYTE0, 1'b1);
			if ($urandom_range(1))
				put(dvbclut_pkg::LEAD_BYTE1, 1'b0);
			put(8'($urandom), 1'b1);
		end else if (pick < 67) begin
			// length cuts the clut body, the rest is hunted through
			put_lead();
			build_clut_body($urandom_range(1, 4), MIXED);
			len = 16'($urandom_range(1, body_bytes.size() - 1));
			put_segment(dvbclut_pkg::CLUT_SEGMENT, 16'($urandom), len);
		end else if (pick < 80) begin
			// overlong segment, left open for the next lead to drop
			put_lead();
			build_clut_body($urandom_range(2, 4), MIXED);
			len = 16'($urandom_range(16'h0100, 16'hFFFF));
			put_segment(dvbclut_pkg::CLUT_SEGMENT, 16'($urandom), len);
		end else begin
			repeat ($urandom_range(1, 6))
				put(8'($urandom), 1'($urandom_range(99) < 15));
		end
	endfunction

	function automatic void put_random_chunk();
		if ($urandom_range(99) < 75) begin
			put_lead();
			repeat ($urandom_range(1, 3))
				put_good_segment();
		end else begin
			put_broken_framing();
		end
	endfunction

	// ---------------------------------------------------------------
	// sender side
	// ---------------------------------------------------------------
	// present one beat at the falling edge, hold it until taken at a rising edge
	task automatic send_byte(input logic [7:0] b, input logic s);
		@(negedge clk);
		while (gaps_on && $urandom_range(99) < IDLE_PERCENT) begin
			in_valid = 1'b0;
			data_byte = 8'($urandom);
			chunk_start = 1'($urandom);
			@(negedge clk);
		end
		in_valid = 1'b1;
		data_byte = b;
		chunk_start = s;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_palette_write(b, s);
		beats_sent++;
	endtask

	task automatic send_pending();
		beat_t bt;
		while (pending.size() != 0) begin
			bt = pending[0];
			pending.delete(0);
			send_byte(bt.data, bt.start);
		end
	endtask

	// drop valid right after the last beat, then wait for every write due
	task automatic wait_drained();
		@(negedge clk);
		in_valid = 1'b0;
		while (palette_writes_due.size() != 0)
			@(posedge clk);
	endtask

	// ---------------------------------------------------------------
	// receiver side: random stalls, or a long hold-off when a test asks
	// ---------------------------------------------------------------
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left != 0) begin
				out_stall = 1'b1;
				hold_left = hold_left - 1;
			end else if (hold_armed != hold_seen) begin
				hold_seen = hold_armed;
				hold_left = HOLD_CYCLES - 1;
				out_stall = 1'b1;
			end else begin
				out_stall = stall_on && ($urandom_range(99) < IDLE_PERCENT);
			end
		end
	end

	// ---------------------------------------------------------------
	// result checking at the rising edge
	// ---------------------------------------------------------------
	task automatic check_field(input string field, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= REPORT_LIMIT)
				$display("mismatch in write %0d, %s: expected %0h, got %0h",
					writes_checked, field, want, got);
		end
	endtask

	always @(posedge clk) begin
		if (out_valid === 1'b1 && out_stall === 1'b0) begin
			if (palette_writes_due.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("palette write with none due: page %0h clut %0h index %0h",
						page_id, clut_id, palette_index);
			end else begin
				due_w = palette_writes_due[0];
				palette_writes_due.delete(0);
				check_field("page_id", due_w.page_id, page_id);
				check_field("clut_id", 16'(due_w.clut_id), 16'(clut_id));
				check_field("clut_version", 16'(due_w.clut_version), 16'(clut_version));
				check_field("palette_index", 16'(due_w.palette_index),
					16'(palette_index));
				check_field("luma", 16'(due_w.luma), 16'(luma));
				check_field("chroma_red", 16'(due_w.chroma_red), 16'(chroma_red));
				check_field("chroma_blue", 16'(due_w.chroma_blue), 16'(chroma_blue));
				check_field("opacity", 16'(due_w.opacity), 16'(opacity));
				check_field("depth_flags", 16'(due_w.depth_flags), 16'(depth_flags));
				check_field("full_range", 16'(due_w.full_range), 16'(full_range));
				writes_checked++;
			end
		end
	end

	// hang guard
	always @(posedge clk) begin
		cycles = cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d writes still due", cycles,
				palette_writes_due.size());
			$display("FAILURE");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------
	// nothing may come out before the first lead, even a broken lead
	task automatic test_unlocked_bytes();
		put(dvbclut_pkg::SYNC_BYTE, 1'b0);
		put(dvbclut_pkg::LEAD_BYTE0, 1'b1);
		put(dvbclut_pkg::LEAD_BYTE2, 1'b0);
		send_pending();
	endtask

	// page ffff, id ff, version f, entry ff wrapping to index 0, full and partial
	task automatic test_clut_extremes();
		put_lead();
		body_bytes = '{8'hFF, 8'hF0,
			8'hFF, 8'hE1, 8'hFF, 8'h00, 8'hFF, 8'h00,
			8'h00, 8'h00, 8'hFF, 8'hFF};
		put_segment(dvbclut_pkg::CLUT_SEGMENT, 16'hFFFF, 16'(body_bytes.size()));
		send_pending();
	endtask

	// zero length segment goes straight back to hunting
	task automatic test_empty_segment();
		body_bytes.delete();
		put_segment(PAGE_SEGMENT, 16'h0000, 16'd0);
		send_pending();
		wait_drained();
	endtask

	task automatic test_framing_errors();
		int stop_at;
		stop_at = beats_sent + 60;
		while (beats_sent < stop_at) begin
			put_broken_framing();
			send_pending();
		end
		wait_drained();
	endtask

	// long receiver hold-off while a dense clut segment keeps coming
	task automatic test_output_hold_off();
		hold_armed++;
		put_lead();
		build_clut_body(30, PARTIAL_ONLY);
		put_segment(dvbclut_pkg::CLUT_SEGMENT, 16'($urandom), 16'(body_bytes.size()));
		send_pending();
		wait_drained();
	endtask

	// first a stretch with no idling on either side, then random idling
	task automatic test_random_stream();
		int stop_at;
		gaps_on = 1'b0;
		stall_on = 1'b0;
		stop_at = beats_sent + 150;
		while (beats_sent < stop_at) begin
			put_random_chunk();
			send_pending();
		end
		gaps_on = 1'b1;
		stall_on = 1'b1;
		stop_at = beats_sent + 200;
		while (beats_sent < stop_at) begin
			put_random_chunk();
			send_pending();
			if ($urandom_range(7) == 0)
				wait_drained();
		end
		wait_drained();
	endtask

	initial begin
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		test_unlocked_bytes();
		test_clut_extremes();
		test_empty_segment();
		test_framing_errors();
		test_output_hold_off();
		test_random_stream();

		// trailing writes from bytes still in flight would show up here
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("run: %0d payload beats, %0d palette writes checked, %0d mismatches",
			beats_sent, writes_checked, mismatches);
		$display("covered locking, relocks, broken leads, cut and skipped segments, hold-off");
		if (mismatches == 0 && palette_writes_due.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("%0d writes never arrived", palette_writes_due.size());
			$display("FAILURE");
		end
		$finish;
	end

endmodule

// ===== dvb_subtitle_clut_segment_parser.f =====
rtl/core/dvbclut_pkg.sv
rtl/core/dvbclut_step.sv
rtl/core/dvb_subtitle_clut_segment_parser.sv
rtl/core/dvbclut_checker.sv
test/testbench.sv
